// ===== design/pmcl_pkg.sv =====
`default_nettype none

package pmcl_pkg;

   localparam int MAX_WIDTH_DEF = 1024;
   localparam int FRAC_BITS     = 14;
   localparam int CORDIC_STEPS  = 24;
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   // input item codes
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // what an offered item will do
   localparam logic [1:0] KIND_NONE  = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   // register indexes
   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;
   localparam logic [1:0] REG_COS    = 2'd2;
   localparam logic [1:0] REG_SIN    = 2'd3;

   // datapath operations
   localparam logic [4:0] DP_NOP    = 5'd0;
   localparam logic [4:0] DP_CORDIC = 5'd1;
   localparam logic [4:0] DP_ROT0   = 5'd2;
   localparam logic [4:0] DP_ROT1   = 5'd3;
   localparam logic [4:0] DP_ROT2   = 5'd4;
   localparam logic [4:0] DP_ROT3   = 5'd5;
   localparam logic [4:0] DP_ROT4   = 5'd6;
   localparam logic [4:0] DP_SQ0    = 5'd7;
   localparam logic [4:0] DP_SQ1    = 5'd8;
   localparam logic [4:0] DP_SQ2    = 5'd9;
   localparam logic [4:0] DP_MEM0   = 5'd10;
   localparam logic [4:0] DP_MEM1   = 5'd11;
   localparam logic [4:0] DP_MEM2   = 5'd12;
   localparam logic [4:0] DP_MEM3   = 5'd13;
   localparam logic [4:0] DP_MEM4   = 5'd14;
   localparam logic [4:0] DP_STN0   = 5'd15;
   localparam logic [4:0] DP_STN1   = 5'd16;
   localparam logic [4:0] DP_FL0    = 5'd17;
   localparam logic [4:0] DP_FL1    = 5'd18;
   localparam logic [4:0] DP_PUSH   = 5'd19;

   typedef struct packed {
      logic        op;
      logic [15:0] intensity;
   } req_type;

   typedef struct packed {
      logic [14:0] pixel_value;
      logic        end_of_plane;
   } rsp_type;

   typedef struct packed {
      logic        [10:0] image_width;
      logic        [15:0] image_height;
      logic signed [15:0] cos_phase;
      logic signed [15:0] sin_phase;
   } cfg_type;

   typedef struct packed {
      logic       accept;
      logic [4:0] op;
      logic [4:0] step;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       emit;
      logic       interior;
      logic       rsp_free;
   } sts_type;

   function automatic logic [29:0] atan_turn(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0:  r = 30'd536870912;
         5'd1:  r = 30'd316933406;
         5'd2:  r = 30'd167458907;
         5'd3:  r = 30'd85004756;
         5'd4:  r = 30'd42667331;
         5'd5:  r = 30'd21354465;
         5'd6:  r = 30'd10679838;
         5'd7:  r = 30'd5340245;
         5'd8:  r = 30'd2670163;
         5'd9:  r = 30'd1335087;
         5'd10: r = 30'd667544;
         5'd11: r = 30'd333772;
         5'd12: r = 30'd166886;
         5'd13: r = 30'd83443;
         5'd14: r = 30'd41722;
         5'd15: r = 30'd20861;
         5'd16: r = 30'd10430;
         5'd17: r = 30'd5215;
         5'd18: r = 30'd2608;
         5'd19: r = 30'd1304;
         5'd20: r = 30'd652;
         5'd21: r = 30'd326;
         5'd22: r = 30'd163;
         5'd23: r = 30'd81;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

   // (s + n) mod 3 for s, n in 0..2
   function automatic logic [1:0] slot_add(input logic [1:0] s, input logic [1:0] n);
      logic [2:0] t;
      t = {1'b0, s} + {1'b0, n};
      return (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
   endfunction

   function automatic logic [14:0] clip15(input logic [15:0] v);
      return v[15] ? 15'h7FFF : v[14:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/pmcl_csr.sv =====
`default_nettype none

module pmcl_csr import pmcl_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   cfg_type cfg_ff;
   logic    wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 11'd1024;
         cfg_ff.image_height <= 16'd1;
         cfg_ff.cos_phase    <= 16'sd16384;
         cfg_ff.sin_phase    <= 16'sd0;
      end else if (wr_en) begin
         unique case (csr_paddr[3:2])
            REG_WIDTH:  cfg_ff.image_width  <= csr_pwdata[10:0];
            REG_HEIGHT: cfg_ff.image_height <= csr_pwdata[15:0];
            REG_COS:    cfg_ff.cos_phase    <= csr_pwdata[15:0];
            REG_SIN:    cfg_ff.sin_phase    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_WIDTH:  csr_prdata = {21'd0, cfg_ff.image_width};
         REG_HEIGHT: csr_prdata = {16'd0, cfg_ff.image_height};
         REG_COS:    csr_prdata = {16'd0, cfg_ff.cos_phase};
         REG_SIN:    csr_prdata = {16'd0, cfg_ff.sin_phase};
         default:    csr_prdata = 32'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== design/pmcl_ctrl.sv =====
`default_nettype none

module pmcl_ctrl import pmcl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_CORD = 5'd1;
   localparam logic [4:0] S_ROT0 = 5'd2;
   localparam logic [4:0] S_ROT1 = 5'd3;
   localparam logic [4:0] S_ROT2 = 5'd4;
   localparam logic [4:0] S_ROT3 = 5'd5;
   localparam logic [4:0] S_ROT4 = 5'd6;
   localparam logic [4:0] S_SQ0  = 5'd7;
   localparam logic [4:0] S_SQ1  = 5'd8;
   localparam logic [4:0] S_SQ2  = 5'd9;
   localparam logic [4:0] S_MEM0 = 5'd10;
   localparam logic [4:0] S_MEM1 = 5'd11;
   localparam logic [4:0] S_MEM2 = 5'd12;
   localparam logic [4:0] S_MEM3 = 5'd13;
   localparam logic [4:0] S_MEM4 = 5'd14;
   localparam logic [4:0] S_STN0 = 5'd15;
   localparam logic [4:0] S_STN1 = 5'd16;
   localparam logic [4:0] S_FL0  = 5'd17;
   localparam logic [4:0] S_FL1  = 5'd18;
   localparam logic [4:0] S_OUT  = 5'd19;

   localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

   logic [4:0] state_ff, state_in;
   logic [4:0] step_ff, step_in;
   logic       accept;

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = (state_ff == S_IDLE) & req_valid;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd.accept = accept;
      cmd.step   = step_ff;
      cmd.op     = DP_NOP;
      unique case (state_ff)
         S_IDLE: begin
            step_in = 5'd0;
            if (req_valid) begin
               case (sts.kind)
                  KIND_PIXEL: state_in = S_CORD;
                  KIND_FLUSH: state_in = S_FL0;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_CORD: begin
            cmd.op = DP_CORDIC;
            if (step_ff == LAST_STEP) begin
               state_in = S_ROT0;
            end else begin
               step_in = step_ff + 5'd1;
            end
         end
         S_ROT0: begin cmd.op = DP_ROT0; state_in = S_ROT1; end
         S_ROT1: begin cmd.op = DP_ROT1; state_in = S_ROT2; end
         S_ROT2: begin cmd.op = DP_ROT2; state_in = S_ROT3; end
         S_ROT3: begin cmd.op = DP_ROT3; state_in = S_ROT4; end
         S_ROT4: begin cmd.op = DP_ROT4; state_in = S_SQ0;  end
         S_SQ0:  begin cmd.op = DP_SQ0;  state_in = S_SQ1;  end
         S_SQ1:  begin cmd.op = DP_SQ1;  state_in = S_SQ2;  end
         S_SQ2:  begin cmd.op = DP_SQ2;  state_in = S_MEM0; end
         S_MEM0: begin
            cmd.op   = DP_MEM0;
            state_in = sts.emit ? S_MEM1 : S_IDLE;
         end
         S_MEM1: begin
            cmd.op   = DP_MEM1;
            state_in = sts.interior ? S_MEM2 : S_OUT;
         end
         S_MEM2: begin cmd.op = DP_MEM2; state_in = S_MEM3; end
         S_MEM3: begin cmd.op = DP_MEM3; state_in = S_MEM4; end
         S_MEM4: begin cmd.op = DP_MEM4; state_in = S_STN0; end
         S_STN0: begin cmd.op = DP_STN0; state_in = S_STN1; end
         S_STN1: begin cmd.op = DP_STN1; state_in = S_OUT;  end
         S_FL0:  begin cmd.op = DP_FL0;  state_in = S_FL1;  end
         S_FL1:  begin cmd.op = DP_FL1;  state_in = S_OUT;  end
         S_OUT: begin
            if (sts.rsp_free) begin
               cmd.op   = DP_PUSH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= 5'd0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/pmcl_dp.sv =====
`default_nettype none

module pmcl_dp import pmcl_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire req_type req_data,
   input  wire cmd_type cmd,
   output sts_type      sts,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int CW    = $clog2(MAX_WIDTH + 1);
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int DEPTH = 3 * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int TSH   = 30 - FRAC_BITS;
   localparam int ASH   = 48 - FRAC_BITS;

   // geometry and position
   logic [CW-1:0] w_eff, x_cand, x1, fx, col_ff, flush_ff;
   logic [CW:0]   flush_p1;
   logic [15:0]   h_eff, r_cand, row_ff;
   logic [1:0]    slot_ff, kind;
   logic          wrap0, wrap1, interior_cand;

   // latched item
   logic [XW-1:0] x_ff;
   logic [1:0]    wr_slot_ff, y_slot_ff, ym_slot_ff;
   logic          emit_ff, interior_ff, eop_ff;

   // CORDIC
   logic signed [33:0] x_c_ff, y_c_ff, sh_x, sh_y, at;
   logic signed [31:0] z_ff, c_val, s_val;
   logic        [1:0]  quad_ff;
   logic        [31:0] turn;

   // arithmetic
   logic signed [31:0] mul_a;
   logic signed [27:0] mul_b, cp28, sp28;
   logic signed [59:0] prod_ff, acc_ff, rot_sum;
   logic signed [27:0] u_ff, v_ff;
   logic        [59:0] a_sum, a_q;
   logic        [15:0] a_ff, c_ff, rdata_ff;
   logic        [17:0] nb_ff;
   logic signed [19:0] d_val;
   logic signed [39:0] st_sum, st_mag;
   logic        [39:0] st_rnd;
   logic        [14:0] res_ff;

   // row store
   logic [15:0]   mem [DEPTH];
   logic [AW-1:0] wr_addr, rd_addr;
   logic [1:0]    rd_slot;
   logic [XW-1:0] rd_x;

   rsp_type rsp_ff;
   logic    rsp_valid_ff, rsp_free;

   function automatic logic [AW-1:0] addr_of(input logic [1:0] s, input logic [XW-1:0] x);
      return AW'(s) * AW'(MAX_WIDTH) + AW'(x);
   endfunction

   // ---------------- geometry ----------------
   always_comb begin
      if (cfg.image_width == 11'd0) begin
         w_eff = CW'(1);
      end else if (32'(cfg.image_width) > MAX_WIDTH) begin
         w_eff = CW'(MAX_WIDTH);
      end else begin
         w_eff = CW'(cfg.image_width);
      end
      h_eff         = (cfg.image_height == 16'd0) ? 16'd1 : cfg.image_height;
      wrap0         = (col_ff >= w_eff);
      r_cand        = wrap0 ? row_ff + 16'd1 : row_ff;
      x_cand        = wrap0 ? '0 : col_ff;
      x1            = x_cand + CW'(1);
      wrap1         = (x1 >= w_eff);
      interior_cand = (h_eff > 16'd2) && (w_eff > CW'(2)) && (r_cand >= 16'd2) &&
                      (r_cand < h_eff) && (x_cand != '0) && (x1 < w_eff);
      fx            = (flush_ff >= w_eff) ? w_eff - CW'(1) : flush_ff;
      flush_p1      = {1'b0, flush_ff} + (CW+1)'(1);
      if (req_data.op == OP_PIXEL) begin
         if (row_ff >= h_eff) begin
            kind = KIND_NONE;
         end else if (wrap0 && (r_cand >= h_eff)) begin
            kind = KIND_NONE;
         end else begin
            kind = KIND_PIXEL;
         end
      end else begin
         kind = (row_ff >= h_eff) ? KIND_FLUSH : KIND_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         flush_ff <= '0;
         slot_ff  <= 2'd0;
      end else if (cmd.accept) begin
         if (kind == KIND_PIXEL) begin
            row_ff  <= wrap1 ? r_cand + 16'd1 : r_cand;
            col_ff  <= wrap1 ? '0 : x1;
            slot_ff <= slot_add(slot_ff, {1'b0, wrap0} + {1'b0, wrap1});
         end else if (kind == KIND_FLUSH) begin
            if (flush_p1 >= {1'b0, w_eff}) begin
               row_ff   <= '0;
               col_ff   <= '0;
               flush_ff <= '0;
               slot_ff  <= 2'd0;
            end else begin
               flush_ff <= flush_ff + CW'(1);
            end
         end else if ((req_data.op == OP_PIXEL) && (row_ff < h_eff) && wrap0) begin
            // row wrap that runs into the plane end
            row_ff  <= r_cand;
            col_ff  <= '0;
            slot_ff <= slot_add(slot_ff, 2'd1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         if (req_data.op == OP_PIXEL) begin
            x_ff        <= x_cand[XW-1:0];
            wr_slot_ff  <= slot_add(slot_ff, {1'b0, wrap0});
            y_slot_ff   <= slot_add(slot_add(slot_ff, {1'b0, wrap0}), 2'd2);
            ym_slot_ff  <= slot_add(slot_add(slot_ff, {1'b0, wrap0}), 2'd1);
            emit_ff     <= (r_cand != 16'd0);
            interior_ff <= interior_cand;
            eop_ff      <= 1'b0;
         end else begin
            x_ff      <= fx[XW-1:0];
            y_slot_ff <= slot_add(slot_ff, 2'd2);
            eop_ff    <= (flush_p1 >= {1'b0, w_eff});
         end
      end
   end

   // ---------------- CORDIC ----------------
   assign turn = {req_data.intensity, TSH'(0)};
   assign sh_x = x_c_ff >>> cmd.step;
   assign sh_y = y_c_ff >>> cmd.step;
   assign at   = $signed({4'b0000, atan_turn(cmd.step)});

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         x_c_ff  <= CORDIC_GAIN;
         y_c_ff  <= '0;
         z_ff    <= $signed({2'b00, turn[29:0]});
         quad_ff <= turn[31:30];
      end else if (cmd.op == DP_CORDIC) begin
         if (!z_ff[31]) begin
            x_c_ff <= x_c_ff - sh_y;
            y_c_ff <= y_c_ff + sh_x;
            z_ff   <= z_ff - at[31:0];
         end else begin
            x_c_ff <= x_c_ff + sh_y;
            y_c_ff <= y_c_ff - sh_x;
            z_ff   <= z_ff + at[31:0];
         end
      end
   end

   always_comb begin
      case (quad_ff)
         2'd0:    begin c_val = x_c_ff[31:0];     s_val = y_c_ff[31:0];     end
         2'd1:    begin c_val = -y_c_ff[31:0];    s_val = x_c_ff[31:0];     end
         2'd2:    begin c_val = -x_c_ff[31:0];    s_val = -y_c_ff[31:0];    end
         default: begin c_val = y_c_ff[31:0];     s_val = -x_c_ff[31:0];    end
      endcase
   end

   // ---------------- shared multiplier ----------------
   assign cp28  = {{12{cfg.cos_phase[15]}}, cfg.cos_phase};
   assign sp28  = {{12{cfg.sin_phase[15]}}, cfg.sin_phase};
   assign d_val = $signed({2'b00, c_ff, 2'b00}) - $signed({2'b00, nb_ff});

   always_comb begin
      case (cmd.op)
         DP_ROT1: begin mul_a = s_val; mul_b = sp28; end
         DP_ROT2: begin mul_a = c_val; mul_b = sp28; end
         DP_ROT3: begin mul_a = s_val; mul_b = cp28; end
         DP_SQ0:  begin mul_a = {{4{u_ff[27]}}, u_ff}; mul_b = u_ff; end
         DP_SQ1:  begin mul_a = {{4{v_ff[27]}}, v_ff}; mul_b = v_ff; end
         DP_STN0: begin mul_a = {{12{d_val[19]}}, d_val}; mul_b = sp28; end
         default: begin mul_a = c_val; mul_b = cp28; end
      endcase
   end

   assign rot_sum = ((cmd.op == DP_ROT2) ? acc_ff - prod_ff : acc_ff + prod_ff)
                    + 60'sd524288;
   assign a_sum   = $unsigned(acc_ff) + ($unsigned(prod_ff) >> 1)
                    + (60'd1 << (ASH - 1));
   assign a_q     = a_sum >> ASH;
   assign st_sum  = $signed({8'd0, c_ff, 16'd0}) + prod_ff[39:0];
   assign st_mag  = st_sum[39] ? -st_sum : st_sum;
   assign st_rnd  = $unsigned(st_mag) + 40'd32768;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (cmd.op)
         DP_ROT1, DP_ROT3, DP_SQ1: acc_ff <= prod_ff;
         DP_ROT2: u_ff <= rot_sum[47:20];
         DP_ROT4: v_ff <= rot_sum[47:20];
         DP_SQ2:  a_ff <= (|a_q[59:16]) ? 16'hFFFF : a_q[15:0];
         DP_MEM1: begin
            c_ff   <= rdata_ff;
            res_ff <= clip15(rdata_ff);
         end
         DP_MEM2: nb_ff <= {2'b00, rdata_ff} + {2'b00, a_ff};
         DP_MEM3, DP_MEM4: nb_ff <= nb_ff + {2'b00, rdata_ff};
         DP_STN1: res_ff <= (|st_rnd[39:31]) ? 15'h7FFF : st_rnd[30:16];
         DP_FL1:  res_ff <= clip15(rdata_ff);
         default: ;
      endcase
   end

   // ---------------- row store ----------------
   always_comb begin
      rd_slot = y_slot_ff;
      rd_x    = x_ff;
      case (cmd.op)
         DP_MEM1: rd_slot = ym_slot_ff;
         DP_MEM2: rd_x    = x_ff - XW'(1);
         DP_MEM3: rd_x    = x_ff + XW'(1);
         default: ;
      endcase
   end

   assign wr_addr = addr_of(wr_slot_ff, x_ff);
   assign rd_addr = addr_of(rd_slot, rd_x);

   always_ff @(posedge clock) begin
      if (cmd.op == DP_MEM0) begin
         mem[wr_addr] <= a_ff;
      end
      rdata_ff <= mem[rd_addr];
   end

   // ---------------- result register ----------------
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == DP_PUSH) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_PUSH) begin
         rsp_ff.pixel_value  <= res_ff;
         rsp_ff.end_of_plane <= eop_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;
   assign sts.kind     = kind;
   assign sts.emit     = emit_ff;
   assign sts.interior = interior_ff;
   assign sts.rsp_free = rsp_free;

endmodule

`default_nettype wire

// ===== design/phase_map_cross_laplacian.sv =====
// Phase-map cross-Laplacian stream filter.
// Input channel (req_valid / req_stall / req_data): pixels of a plane in raster
// order (op pixel) and, once a plane is complete, one flush item per pixel of
// its last row (op flush). Result channel (rsp_valid / rsp_stall / rsp_data):
// pixel_value and end_of_plane, one row behind the input; row 0 pixels give
// no result, the flush transfers give the last row.
// Configuration through the csr_ APB-style port: width, height, phase cos/sin;
// write only between items.
// Timing: one item at a time. A pixel passes the 24-step CORDIC, then the
// rotation and the squares on the single shared multiplier, then the row
// store and, for an interior result, the stencil; a flush item only reads
// the row store. req_stall is high from the transfer until the result sits
// in the output register (a row 0 pixel: until its row store write); while
// idle, ignored items transfer at one per cycle.
// A stalled receiver holds the result register, and the block holds in its
// final state until that register frees.
// Reset clears counters, state and rsp_valid and sets the default config;
// the row store keeps garbage until written and needs no clearing pass.
`default_nettype none

module phase_map_cross_laplacian import pmcl_pkg::*; #(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_data,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [3:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   cfg_type cfg;
   cmd_type cmd;
   sts_type sts;

   // register bank
   pmcl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequencer: pixels through CORDIC, rotation, squares, stencil if interior
   pmcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // counters, arithmetic, row store and the result register
   pmcl_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/pmcl_checker.sv =====
`default_nettype none

module pmcl_checker import pmcl_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("held result changed");

   // reset empties the result register
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a fresh result only comes out of a busy block
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while idle");

endmodule

bind phase_map_cross_laplacian pmcl_checker u_pmcl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
